// ===== sv/qnpd_pkg.sv =====
// Shared types and constants of the nearest-point demapper.
`default_nettype none

package qnpd_pkg;

  localparam int PIDX_W   = 6;   // load index field
  localparam int SYM_W    = 6;   // result index field
  localparam int CNT_REG_W = 7;  // point count register
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REAL_MODE   = 1'b0,
    REG_POINT_COUNT = 1'b1
  } cfg_reg_t;

  // control part of a word travelling down the chain
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [PIDX_W-1:0] point_index;
  } item_ctl_t;

endpackage

`default_nettype wire

// ===== sv/qnpd_if.sv =====
// Channel interfaces of the nearest-point demapper: input, result and configuration.
`default_nettype none

interface qnpd_in_if #(parameter int SAMPLE_BITS = 16);
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [qnpd_pkg::PIDX_W-1:0]         point_index;
  logic signed [SAMPLE_BITS-1:0]       in_i;
  logic signed [SAMPLE_BITS-1:0]       in_q;

  modport source (output valid, kind, point_index, in_i, in_q, input ready);
  modport sink   (input valid, kind, point_index, in_i, in_q, output ready);
endinterface

interface qnpd_out_if;
  logic                        valid;
  logic                        ready;
  logic [qnpd_pkg::SYM_W-1:0]  symbol_index;

  modport source (output valid, symbol_index, input ready);
  modport sink   (input valid, symbol_index, output ready);
endinterface

interface qnpd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [qnpd_pkg::CFG_IDX_W-1:0]   index;
  logic [qnpd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/qnpd_cell.sv =====
// One cell of the demapper chain: holds one constellation point and updates the running best.
`default_nettype none

module qnpd_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int IDX_W       = 6,
  parameter int CNT_W       = 7,
  parameter int CELL_IDX    = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          real_mode,
  input  logic [CNT_W-1:0]              count_lim,
  input  qnpd_pkg::item_ctl_t           ctl_in,
  input  logic signed [SAMPLE_BITS-1:0] smp_i_in,
  input  logic signed [SAMPLE_BITS-1:0] smp_q_in,
  input  logic [2*SAMPLE_BITS+1:0]      best_d_in,
  input  logic [IDX_W-1:0]              best_k_in,
  output qnpd_pkg::item_ctl_t           ctl_out,
  output logic signed [SAMPLE_BITS-1:0] smp_i_out,
  output logic signed [SAMPLE_BITS-1:0] smp_q_out,
  output logic [2*SAMPLE_BITS+1:0]      best_d_out,
  output logic [IDX_W-1:0]              best_k_out
);
  import qnpd_pkg::*;

  localparam int DIF_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = 2 * DIF_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS + 1;
  localparam int DIST_W = 2 * SAMPLE_BITS + 2;

  // stored point
  logic signed [SAMPLE_BITS-1:0] pt_i_r, pt_q_r;
  logic                          pt_wr;

  // stage A: squared differences
  item_ctl_t                     ctl_a_r;
  logic signed [SAMPLE_BITS-1:0] smp_i_a_r, smp_q_a_r;
  logic [DIST_W-1:0]             best_d_a_r;
  logic [IDX_W-1:0]              best_k_a_r;
  logic [SQ_W-1:0]               sq_i_a_r, sq_q_a_r;
  logic signed [DIF_W-1:0]       dif_i, dif_q;
  logic signed [PROD_W-1:0]      prod_i, prod_q;
  logic [SQ_W-1:0]               sq_i_nxt, sq_q_nxt;

  // stage B: sum, compare, hand on
  item_ctl_t                     ctl_b_r;
  logic signed [SAMPLE_BITS-1:0] smp_i_b_r, smp_q_b_r;
  logic [DIST_W-1:0]             best_d_b_r, best_d_nxt, dist_sum;
  logic [IDX_W-1:0]              best_k_b_r, best_k_nxt;
  logic                          active, take;

  always_comb begin
    pt_wr    = adv && ctl_in.valid && (ctl_in.kind == KIND_LOAD) &&
               (int'(ctl_in.point_index) == CELL_IDX);
    dif_i    = DIF_W'(smp_i_in) - DIF_W'(pt_i_r);
    dif_q    = DIF_W'(smp_q_in) - DIF_W'(pt_q_r);
    prod_i   = PROD_W'(dif_i) * PROD_W'(dif_i);
    prod_q   = PROD_W'(dif_q) * PROD_W'(dif_q);
    sq_i_nxt = SQ_W'(prod_i);
    sq_q_nxt = SQ_W'(prod_q);
  end

  always_ff @(posedge clk) begin
    if (pt_wr) begin
      pt_i_r <= smp_i_in;
      pt_q_r <= smp_q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else if (adv) begin
      ctl_a_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp_i_a_r  <= smp_i_in;
      smp_q_a_r  <= smp_q_in;
      best_d_a_r <= best_d_in;
      best_k_a_r <= best_k_in;
      sq_i_a_r   <= sq_i_nxt;
      sq_q_a_r   <= sq_q_nxt;
    end
  end

  always_comb begin
    if (real_mode) begin
      dist_sum = DIST_W'(sq_i_a_r);
    end else begin
      dist_sum = DIST_W'(sq_i_a_r) + DIST_W'(sq_q_a_r);
    end
    active = CELL_IDX < int'(count_lim);
    // first cell always seeds the best; later cells replace only on a strictly smaller distance
    take   = ctl_a_r.valid && (ctl_a_r.kind == KIND_SAMPLE) && active &&
             ((CELL_IDX == 0) || (dist_sum < best_d_a_r));
    best_d_nxt = take ? dist_sum : best_d_a_r;
    best_k_nxt = take ? IDX_W'(CELL_IDX) : best_k_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else if (adv) begin
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp_i_b_r  <= smp_i_a_r;
      smp_q_b_r  <= smp_q_a_r;
      best_d_b_r <= best_d_nxt;
      best_k_b_r <= best_k_nxt;
    end
  end

  assign ctl_out    = ctl_b_r;
  assign smp_i_out  = smp_i_b_r;
  assign smp_q_out  = smp_q_b_r;
  assign best_d_out = best_d_b_r;
  assign best_k_out = best_k_b_r;

endmodule

`default_nettype wire

// ===== sv/qam_nearest_point_demapper_core.sv =====
// Top level of the nearest-point demapper: configuration registers, cell chain, output register.
//
// Channels: in_ch carries load words (kind 0: write point in_i/in_q to entry point_index)
// and sample words (kind 1: find the nearest of entries 0 to point_count-1, with the count
// clamped to 1..MAX_POINTS). out_ch returns one symbol_index per sample word, lowest index
// on equal distance; loads return nothing. cfg_ch writes real_mode (index 0) and
// point_count (index 1); it is always ready and must only be written while no word is in flight.
// Throughput: one word per cycle while out_ch is not stalled. Every word walks a chain of
// MAX_POINTS cells, two register stages per cell (squaring, then sum and compare), followed
// by the output register. Loads travel the same chain, so a load always takes effect
// before any later sample reaches that entry.
// Reset clears the chain's valid bits, the output valid bit, real_mode (0) and
// point_count (64); table entries hold nothing useful until loaded.
// When out_ch stalls with a result waiting, the whole chain and in_ch.ready hold.
`default_nettype none

module qam_nearest_point_demapper_core #(
  parameter int MAX_POINTS  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  qnpd_in_if.sink    in_ch,
  qnpd_out_if.source out_ch,
  qnpd_cfg_if.sink   cfg_ch
);
  import qnpd_pkg::*;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIST_W = 2 * SAMPLE_BITS + 2;

  logic                   real_mode_r;
  logic [CNT_REG_W-1:0]   point_count_r;
  logic [CNT_W-1:0]       count_lim;
  logic                   adv;
  logic                   out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]       out_idx_r, out_idx_nxt;

  item_ctl_t                     ctl_w    [0:MAX_POINTS];
  logic signed [SAMPLE_BITS-1:0] smp_i_w  [0:MAX_POINTS];
  logic signed [SAMPLE_BITS-1:0] smp_q_w  [0:MAX_POINTS];
  logic [DIST_W-1:0]             best_d_w [0:MAX_POINTS];
  logic [IDX_W-1:0]              best_k_w [0:MAX_POINTS];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_mode_r   <= 1'b0;
      point_count_r <= CNT_REG_W'(64);
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_REAL_MODE:   real_mode_r   <= cfg_ch.data[0];
        REG_POINT_COUNT: point_count_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // clamp the count to one..MAX_POINTS
  always_comb begin
    if (point_count_r == '0) begin
      count_lim = CNT_W'(1);
    end else if (int'(point_count_r) > MAX_POINTS) begin
      count_lim = CNT_W'(MAX_POINTS);
    end else begin
      count_lim = CNT_W'(point_count_r);
    end
  end

  // advance the chain whenever the output register can take the tail word
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign ctl_w[0]    = '{valid: in_ch.valid, kind: kind_t'(in_ch.kind),
                         point_index: in_ch.point_index};
  assign smp_i_w[0]  = in_ch.in_i;
  assign smp_q_w[0]  = in_ch.in_q;
  assign best_d_w[0] = '0;
  assign best_k_w[0] = '0;

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    qnpd_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W),
      .CELL_IDX    (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .real_mode  (real_mode_r),
      .count_lim  (count_lim),
      .ctl_in     (ctl_w[k]),
      .smp_i_in   (smp_i_w[k]),
      .smp_q_in   (smp_q_w[k]),
      .best_d_in  (best_d_w[k]),
      .best_k_in  (best_k_w[k]),
      .ctl_out    (ctl_w[k+1]),
      .smp_i_out  (smp_i_w[k+1]),
      .smp_q_out  (smp_q_w[k+1]),
      .best_d_out (best_d_w[k+1]),
      .best_k_out (best_k_w[k+1])
    );
  end

  // output register: samples leave the chain as results, loads are dropped
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    if (adv) begin
      out_valid_nxt = ctl_w[MAX_POINTS].valid && (ctl_w[MAX_POINTS].kind == KIND_SAMPLE);
      out_idx_nxt   = SYM_W'(best_k_w[MAX_POINTS]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r <= out_idx_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.symbol_index = out_idx_r;

endmodule

`default_nettype wire

// ===== sv/qnpd_checker.sv =====
// Port-level assertions for the nearest-point demapper and their bind to the top level.
`default_nettype none

module qnpd_checker #(
  parameter int MAX_POINTS = 64
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [qnpd_pkg::SYM_W-1:0]   symbol_index,
  input logic                         cfg_ready
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(symbol_index))
    else $error("result changed while stalled");

  // input is taken exactly when the result side can move
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow result side");

  // a result never names an entry beyond the table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(symbol_index) < MAX_POINTS))
    else $error("result index beyond table");

  // nothing is offered straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind qam_nearest_point_demapper_core qnpd_checker #(
  .MAX_POINTS (MAX_POINTS)
) u_qnpd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .symbol_index (out_ch.symbol_index),
  .cfg_ready    (cfg_ch.ready)
);

`default_nettype wire

// ===== test/qnpd_demap_checker.sv =====
// Watches the demapper's channels, predicts each nearest-point symbol and compares it.
module qnpd_demap_checker #(
  parameter int MAX_POINTS  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  qnpd_in_if   in_ch,
  qnpd_out_if  out_ch,
  qnpd_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import qnpd_pkg::*;

  logic signed [SAMPLE_BITS-1:0] const_i [MAX_POINTS];
  logic signed [SAMPLE_BITS-1:0] const_q [MAX_POINTS];
  logic                          i_only;
  logic [CNT_REG_W-1:0]          search_count;
  logic [SYM_W-1:0]              symbols_due[$];
  int                            errors;

  initial begin
    fail_count = 0;
    pending    = 0;
    errors     = 0;
    for (int k = 0; k < MAX_POINTS; k++) begin
      const_i[k] = '0;
      const_q[k] = '0;
    end
  end

  // exact squared distance; the first of equal distances is kept
  function automatic logic [SYM_W-1:0] nearest_symbol(input logic signed [SAMPLE_BITS-1:0] si,
                                                       input logic signed [SAMPLE_BITS-1:0] sq);
    longint best;
    longint d_sum;
    longint di;
    longint dq;
    int n;
    logic [SYM_W-1:0] win;
    n = int'(search_count);
    if (n < 1) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    win  = '0;
    best = 0;
    for (int k = 0; k < n; k++) begin
      di    = longint'(si) - longint'(const_i[k]);
      dq    = longint'(sq) - longint'(const_q[k]);
      d_sum = di * di;
      if (!i_only) d_sum += dq * dq;
      if (k == 0 || d_sum < best) begin
        best = d_sum;
        win  = SYM_W'(k);
      end
    end
    return win;
  endfunction

  always @(posedge clk) begin
    logic [SYM_W-1:0] want;
    if (!rst_n) begin
      i_only       = 1'b0;
      search_count = CNT_REG_W'(MAX_POINTS);
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_REAL_MODE:   i_only = cfg_ch.data[0];
          REG_POINT_COUNT: search_count = cfg_ch.data[CNT_REG_W-1:0];
          default: ;
        endcase
      end
      // loads walk the same chain as samples, so apply them in arrival order
      if (in_ch.valid && in_ch.ready) begin
        if (kind_t'(in_ch.kind) == KIND_LOAD) begin
          const_i[in_ch.point_index] = in_ch.in_i;
          const_q[in_ch.point_index] = in_ch.in_q;
        end else begin
          symbols_due.push_back(nearest_symbol(in_ch.in_i, in_ch.in_q));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (symbols_due.size() == 0) begin
          errors++;
          $display("%0t: symbol_index expected none, got %0d", $time, out_ch.symbol_index);
        end else begin
          want = symbols_due.pop_front();
          if (out_ch.symbol_index !== want) begin
            errors++;
            $display("%0t: symbol_index expected %0d, got %0d", $time, want,
                     out_ch.symbol_index);
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= symbols_due.size();
  end

endmodule

// ===== test/testbench.sv =====
// Stimulus, idling and verdict for the nearest-point demapper.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qnpd_pkg::*;

  localparam int MAX_POINTS  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int DRAIN       = 2 * MAX_POINTS + 12;
  localparam int LIMIT       = 300000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_pct;
  int   stall_pct;
  int   hold_left;

  // what has been loaded, kept only to aim samples at the table
  logic signed [SAMPLE_BITS-1:0] shadow_i [MAX_POINTS];
  logic signed [SAMPLE_BITS-1:0] shadow_q [MAX_POINTS];
  bit                            loaded   [MAX_POINTS];

  qnpd_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  qnpd_out_if                             out_ch ();
  qnpd_cfg_if                             cfg_ch ();

  qam_nearest_point_demapper_core #(
    .MAX_POINTS (MAX_POINTS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  qnpd_demap_checker #(
    .MAX_POINTS (MAX_POINTS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when asked
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  task automatic push_word(input kind_t k, input logic [PIDX_W-1:0] idx,
                           input logic signed [SAMPLE_BITS-1:0] vi,
                           input logic signed [SAMPLE_BITS-1:0] vq);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.point_index <= idx;
    in_ch.in_i        <= vi;
    in_ch.in_q        <= vq;
    if (k == KIND_LOAD) begin
      shadow_i[idx] = vi;
      shadow_q[idx] = vq;
      loaded[idx]   = 1'b1;
    end
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // drop valid, wait for every symbol, then let loads clear the chain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_config(input logic i_only, input logic [CNT_REG_W-1:0] count);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_REAL_MODE;
    cfg_ch.data  <= CFG_DATA_W'(i_only);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_POINT_COUNT;
    cfg_ch.data  <= CFG_DATA_W'(count);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic make_point(output logic signed [SAMPLE_BITS-1:0] vi,
                            output logic signed [SAMPLE_BITS-1:0] vq);
    int k;
    case ($urandom_range(0, 3))
      0: begin
        vi = 16'($urandom);
        vq = 16'($urandom);
      end
      1: begin
        // 16-QAM style grid
        vi = 16'((int'($urandom_range(0, 3)) * 2 - 3) * 8192);
        vq = 16'((int'($urandom_range(0, 3)) * 2 - 3) * 8192);
      end
      2: begin
        // copy another entry so that distances tie
        k  = $urandom_range(0, MAX_POINTS - 1);
        vi = loaded[k] ? shadow_i[k] : extreme_value();
        vq = loaded[k] ? shadow_q[k] : extreme_value();
      end
      default: begin
        vi = extreme_value();
        vq = extreme_value();
      end
    endcase
  endtask

  task automatic make_sample(input int span, output logic signed [SAMPLE_BITS-1:0] vi,
                             output logic signed [SAMPLE_BITS-1:0] vq);
    int a;
    int b;
    a = $urandom_range(0, span - 1);
    b = $urandom_range(0, span - 1);
    case ($urandom_range(0, 4))
      0: begin
        vi = 16'($urandom);
        vq = 16'($urandom);
      end
      1: begin
        vi = shadow_i[a] + 16'(int'($urandom_range(0, 512)) - 256);
        vq = shadow_q[a] + 16'(int'($urandom_range(0, 512)) - 256);
      end
      2: begin
        vi = shadow_i[a];
        vq = shadow_q[a];
      end
      3: begin
        // halfway between two entries: equal distances where the sum is even
        vi = 16'((int'(shadow_i[a]) + int'(shadow_i[b])) >>> 1);
        vq = 16'((int'(shadow_q[a]) + int'(shadow_q[b])) >>> 1);
      end
      default: begin
        vi = extreme_value();
        vq = extreme_value();
      end
    endcase
  endtask

  task automatic run_phase(input logic i_only, input int count, input int idle,
                           input int stall, input int n_words, input int hold);
    int span;
    logic signed [SAMPLE_BITS-1:0] vi;
    logic signed [SAMPLE_BITS-1:0] vq;
    logic [PIDX_W-1:0] idx;
    wait_idle();
    idle_pct  = idle;
    stall_pct = stall;
    write_config(i_only, CNT_REG_W'(count));
    span = (count < 1) ? 1 : (count > MAX_POINTS) ? MAX_POINTS : count;
    // every searched entry must hold a point before the first sample
    for (int k = 0; k < span; k++) begin
      if (!loaded[k]) begin
        make_point(vi, vq);
        push_word(KIND_LOAD, PIDX_W'(k), vi, vq);
      end
    end
    hold_left = hold;
    repeat (n_words) begin
      if ($urandom_range(0, 99) < 20) begin
        idx = ($urandom_range(0, 9) < 7) ? PIDX_W'($urandom_range(0, span - 1))
                                          : PIDX_W'($urandom);
        make_point(vi, vq);
        push_word(KIND_LOAD, idx, vi, vq);
      end else begin
        make_sample(span, vi, vq);
        push_word(KIND_SAMPLE, PIDX_W'($urandom), vi, vq);
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_LOAD;
    in_ch.point_index <= '0;
    in_ch.in_i        <= '0;
    in_ch.in_q        <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_REAL_MODE;
    cfg_ch.data       <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    for (int k = 0; k < MAX_POINTS; k++) loaded[k] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corner points, a duplicate entry and the top load index
    write_config(1'b0, 7'd4);
    push_word(KIND_LOAD, 6'd0, 16'sh8000, 16'sh8000);
    push_word(KIND_LOAD, 6'd1, 16'sh7fff, 16'sh7fff);
    push_word(KIND_LOAD, 6'd2, 16'sh0000, 16'sh0000);
    push_word(KIND_LOAD, 6'd3, 16'sh0000, 16'sh0000);
    push_word(KIND_LOAD, 6'd63, 16'sh8000, 16'sh7fff);
    push_word(KIND_SAMPLE, 6'd63, 16'sh8000, 16'sh8000);
    push_word(KIND_SAMPLE, 6'd0, 16'sh7fff, 16'sh7fff);
    push_word(KIND_SAMPLE, 6'd21, 16'sh0000, 16'sh0000);
    push_word(KIND_SAMPLE, 6'd42, 16'sh7fff, 16'sh8000);
    push_word(KIND_SAMPLE, 6'd63, 16'shffff, 16'shffff);
    push_word(KIND_SAMPLE, 6'd0, 16'sh4000, 16'sh3fff);
    push_word(KIND_SAMPLE, 6'd5, 16'sh8000, 16'sh7fff);
    wait_idle();
    write_config(1'b1, 7'd4);
    push_word(KIND_SAMPLE, 6'd63, 16'sh0000, 16'sh7fff);
    push_word(KIND_SAMPLE, 6'd0, 16'sh7fff, 16'sh8000);
    push_word(KIND_SAMPLE, 6'd9, -16'sd20000, 16'sh0005);

    // random phases: register settings with different idling
    run_phase(1'b0, 64, 0, 0, 60, 0);
    run_phase(1'b1, 16, 63, 0, 60, 0);
    run_phase(1'b0, 0, 0, 63, 40, 0);
    run_phase(1'b1, 127, 13, 13, 50, 0);
    // long hold-off with more words than the chain holds, so the input stalls
    run_phase(1'b0, 2, 0, 0, 200, 400);
    run_phase(1'b0, 37, 13, 13, 50, 0);
    run_phase(1'b1, 1, 63, 0, 30, 0);
    run_phase(1'b0, 64, 0, 63, 50, 0);
    run_phase(1'b1, 64, 13, 13, 40, 0);
    wait_idle();

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
